// ===== rtl/handheld_memory_map_decoder_core_defines.svh =====
// Assertion macros for the handheld memory map decoder.
// Included by the core module, which carries concurrent assertions; no other dependencies.
`ifndef HANDHELD_MEMORY_MAP_DECODER_CORE_DEFINES_SVH
`define HANDHELD_MEMORY_MAP_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define HMMD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hmmd assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define HMMD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hmmd assertion failed");

`else

`define HMMD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HMMD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/hmmd_pkg.sv =====
// Shared types and constants of the handheld memory map decoder.
// No dependencies; used by the core module and the testbench.
`default_nettype none

package hmmd_pkg;

    // Storage sizes and their index widths.
    localparam int WORK_RAM_BYTES = 8192;
    localparam int HIGH_RAM_BYTES = 128;
    localparam int SPRITE_BYTES   = 160;
    localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
    localparam int HRAM_AW        = $clog2(HIGH_RAM_BYTES);
    localparam int SPR_AW         = $clog2(SPRITE_BYTES);

    // Item kinds.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PAD   = 2'd2;
    localparam logic [1:0] MODE_IRQ   = 2'd3;

    // Fixed register addresses.
    localparam logic [15:0] ADDR_PAD   = 16'hFF00;
    localparam logic [15:0] ADDR_IF    = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA   = 16'hFF46;
    localparam logic [15:0] ADDR_SPEED = 16'hFF4D;
    localparam logic [15:0] ADDR_BOOT  = 16'hFF50;
    localparam logic [15:0] ADDR_IE    = 16'hFFFF;

    // Interrupt request bits and the joypad request bit.
    localparam logic [7:0] IRQ_MASK = 8'h1F;
    localparam logic [7:0] IRQ_PAD  = 8'h10;

    // Where an access goes.
    typedef enum logic [3:0] {
        TGT_INTERNAL = 4'd0,
        TGT_CART     = 4'd1,
        TGT_BOOT     = 4'd2,
        TGT_VRAM     = 4'd3,
        TGT_SOUND    = 4'd4,
        TGT_VIDEO    = 4'd5,
        TGT_TIMER    = 4'd6,
        TGT_DMA      = 4'd7,
        TGT_IGNORED  = 4'd8
    } t_target;

    // Source of the read byte once the memories have answered.
    typedef enum logic [2:0] {
        SRC_REG  = 3'd0,
        SRC_WRAM = 3'd1,
        SRC_ERAM = 3'd2,
        SRC_HRAM = 3'd3,
        SRC_OAM  = 3'd4
    } t_src;

    // One input beat.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  buttons;
        logic [4:0]  irq_bits;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic [7:0]  read_data;
        t_target     target;
        logic [15:0] local_offset;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== rtl/handheld_memory_map_decoder_core.sv =====
// Top level of the handheld memory map decoder: decode, internal memories and registers.
// Depends on hmmd_pkg and handheld_memory_map_decoder_core_defines.svh.
`default_nettype none

// Takes one bus access or event beat per clock while the input is not stalled, and returns
// one result beat per input beat through the memory read register and then the output
// register. Back-to-back beats flow without bubbles; outside the clearing pass the input
// stalls only when the result side stalls. After reset the block runs a clearing pass that
// zeroes work RAM, external RAM, high RAM and sprite memory in parallel; the input is
// stalled for that time. A write is visible to a read accepted in the very next cycle.
module handheld_memory_map_decoder_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  hmmd_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output hmmd_pkg::t_out_beat   o_out_data
);
    import hmmd_pkg::*;

`include "handheld_memory_map_decoder_core_defines.svh"

    // Memories.
    logic [7:0] r_wram [WORK_RAM_BYTES];
    logic [7:0] r_eram [WORK_RAM_BYTES];
    logic [7:0] r_hram [HIGH_RAM_BYTES];
    logic [7:0] r_oam  [SPRITE_BYTES];

    // Architectural registers.
    logic       r_boot_on;
    logic [4:0] r_ie;
    logic [7:0] r_if;
    logic [7:0] r_speed;
    logic [1:0] r_psel;
    logic [7:0] r_pad;

    // Clearing pass.
    logic               r_clr_busy;
    logic [WRAM_AW-1:0] r_clr_idx;

    // Stage one: decoded beat plus registered memory read data.
    logic        r_s1_vld;
    t_target     r_s1_tgt;
    logic [15:0] r_s1_off;
    t_src        r_s1_src;
    logic [7:0]  r_s1_byte;
    logic [7:0]  r_wram_q;
    logic [7:0]  r_eram_q;
    logic [7:0]  r_hram_q;
    logic [7:0]  r_oam_q;

    // Output register.
    logic      r_out_vld;
    t_out_beat r_out;

    // Handshake and decode signals.
    logic        s1_adv;
    logic        acc;
    logic        is_rd;
    logic        is_wr;
    logic [15:0] a;
    logic [7:0]  lo;
    logic [7:0]  v;
    t_target     dec_tgt;
    logic [15:0] dec_off;
    t_src        dec_src;
    logic [7:0]  dec_byte;
    logic        we_wram;
    logic        we_eram;
    logic        we_hram;
    logic        we_oam;
    logic        n_boot_on;
    logic [4:0]  n_ie;
    logic [7:0]  n_if;
    logic [7:0]  n_speed;
    logic [1:0]  n_psel;
    logic [7:0]  n_pad;
    logic [7:0]  pad_byte;
    logic [7:0]  s1_data;

    // Pipeline flow control.
    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_vld && !s1_adv);
    assign acc        = i_in_valid && !o_in_stall;

    assign a     = i_in_data.address;
    assign lo    = i_in_data.address[7:0];
    assign v     = i_in_data.write_data;
    assign is_rd = acc && (i_in_data.mode == MODE_READ);
    assign is_wr = acc && (i_in_data.mode == MODE_WRITE);

    // Joypad read byte from the selected group; pressed buttons read as zero.
    always_comb begin
        if (r_psel[1]) begin
            pad_byte = 8'h20 | {4'h0, ~r_pad[3:0]};
        end else if (r_psel[0]) begin
            pad_byte = 8'h10 | {4'h0, ~r_pad[7:4]};
        end else begin
            pad_byte = 8'h0F;
        end
    end

    // Address decode and register updates for the beat at the input.
    always_comb begin
        dec_tgt   = TGT_INTERNAL;
        dec_off   = 16'h0000;
        dec_src   = SRC_REG;
        dec_byte  = 8'h00;
        we_wram   = 1'b0;
        we_eram   = 1'b0;
        we_hram   = 1'b0;
        we_oam    = 1'b0;
        n_boot_on = r_boot_on;
        n_ie      = r_ie;
        n_if      = r_if;
        n_speed   = r_speed;
        n_psel    = r_psel;
        n_pad     = r_pad;

        if (i_in_data.mode == MODE_READ || i_in_data.mode == MODE_WRITE) begin
            if (!a[15]) begin
                // Cartridge ROM, with the boot ROM overlaid on the first page.
                if (is_wr || i_in_data.mode == MODE_WRITE) begin
                    dec_tgt = TGT_IGNORED;
                end else begin
                    dec_off = a;
                    dec_tgt = (r_boot_on && a[15:8] == 8'h00) ? TGT_BOOT : TGT_CART;
                end
            end else if (a[15:13] == 3'b100) begin
                dec_tgt = TGT_VRAM;
                dec_off = {3'b000, a[12:0]};
            end else if (a[15:13] == 3'b101) begin
                dec_src = SRC_ERAM;
                we_eram = is_wr;
            end else if (a[15:9] != 7'h7F) begin
                // Work RAM and its echo.
                dec_src = SRC_WRAM;
                we_wram = is_wr;
            end else if (a[15:8] == 8'hFE) begin
                // Sprite memory; the unused tail reads zero and drops writes.
                if (lo < 8'(SPRITE_BYTES)) begin
                    dec_src = SRC_OAM;
                    we_oam  = is_wr;
                end else if (i_in_data.mode == MODE_WRITE) begin
                    dec_tgt = TGT_IGNORED;
                end
            end else if (a == ADDR_IE) begin
                dec_byte = {3'b000, r_ie};
                if (is_wr) begin
                    n_ie = v[4:0];
                end
            end else if (lo[7]) begin
                dec_src = SRC_HRAM;
                we_hram = is_wr;
            end else if (a == ADDR_DMA && i_in_data.mode == MODE_WRITE) begin
                dec_tgt = TGT_DMA;
                dec_off = {v, 8'h00};
            end else if (a == ADDR_BOOT) begin
                dec_byte = {7'h00, r_boot_on};
                if (is_wr && v != 8'h00) begin
                    n_boot_on = 1'b0;
                end
            end else if (a == ADDR_SPEED) begin
                dec_byte = r_speed;
                if (is_wr) begin
                    n_speed = v;
                end
            end else if (a == ADDR_PAD) begin
                dec_byte = pad_byte;
                if (is_wr) begin
                    n_psel = {~v[5], ~v[4]};
                end
            end else if (a == ADDR_IF) begin
                dec_byte = r_if;
                if (is_wr) begin
                    n_if = v;
                end
            end else begin
                // Remaining IO page: timer/serial, sound, video, or unmapped.
                if (lo inside {8'h01, 8'h02, [8'h04:8'h07]}) begin
                    dec_tgt = TGT_TIMER;
                    dec_off = {8'h00, lo};
                end else if (lo >= 8'h10 && lo < 8'h40) begin
                    dec_tgt = TGT_SOUND;
                    dec_off = {8'h00, 8'(lo - 8'h10)};
                end else if (lo >= 8'h40 && lo < 8'h50) begin
                    dec_tgt = TGT_VIDEO;
                    dec_off = {8'h00, 8'(lo - 8'h40)};
                end else if (i_in_data.mode == MODE_WRITE) begin
                    dec_tgt = TGT_IGNORED;
                end
            end
        end else if (i_in_data.mode == MODE_PAD) begin
            if (acc && i_in_data.buttons != r_pad) begin
                n_pad = i_in_data.buttons;
                n_if  = (r_if | IRQ_PAD) & IRQ_MASK;
            end
        end else begin
            if (acc) begin
                n_if = (r_if | {3'b000, i_in_data.irq_bits}) & IRQ_MASK;
            end
        end
    end

    // Register file, clearing pass and pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_on  <= 1'b1;
            r_ie       <= 5'h00;
            r_if       <= 8'h00;
            r_speed    <= 8'h00;
            r_psel     <= 2'b00;
            r_pad      <= 8'h00;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_boot_on <= n_boot_on;
            r_ie      <= n_ie;
            r_if      <= n_if;
            r_speed   <= n_speed;
            r_psel    <= n_psel;
            r_pad     <= n_pad;
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (&r_clr_idx) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Stage one payload, loaded with each accepted beat.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_tgt  <= dec_tgt;
            r_s1_off  <= dec_off;
            r_s1_src  <= is_rd ? dec_src : SRC_REG;
            r_s1_byte <= is_rd ? dec_byte : 8'h00;
        end
    end

    // Work RAM: clearing write, access write, registered read.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_wram[r_clr_idx] <= 8'h00;
        end else if (we_wram) begin
            r_wram[a[WRAM_AW-1:0]] <= v;
        end
        if (acc) begin
            r_wram_q <= r_wram[a[WRAM_AW-1:0]];
        end
    end

    // External RAM: clearing write, access write, registered read.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_eram[r_clr_idx] <= 8'h00;
        end else if (we_eram) begin
            r_eram[a[WRAM_AW-1:0]] <= v;
        end
        if (acc) begin
            r_eram_q <= r_eram[a[WRAM_AW-1:0]];
        end
    end

    // High RAM: clearing write, access write, registered read.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_hram[r_clr_idx[HRAM_AW-1:0]] <= 8'h00;
        end else if (we_hram) begin
            r_hram[a[HRAM_AW-1:0]] <= v;
        end
        if (acc) begin
            r_hram_q <= r_hram[a[HRAM_AW-1:0]];
        end
    end

    // Sprite memory: cleared over its own depth, read only inside its range.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (r_clr_idx < WRAM_AW'(SPRITE_BYTES)) begin
                r_oam[r_clr_idx[SPR_AW-1:0]] <= 8'h00;
            end
        end else if (we_oam) begin
            r_oam[a[SPR_AW-1:0]] <= v;
        end
        if (acc && a[SPR_AW-1:0] < SPR_AW'(SPRITE_BYTES)) begin
            r_oam_q <= r_oam[a[SPR_AW-1:0]];
        end
    end

    // Pick the read byte from the answering source.
    always_comb begin
        case (r_s1_src)
            SRC_WRAM: s1_data = r_wram_q;
            SRC_ERAM: s1_data = r_eram_q;
            SRC_HRAM: s1_data = r_hram_q;
            SRC_OAM:  s1_data = r_oam_q;
            default:  s1_data = r_s1_byte;
        endcase
    end

    // Output register, held while the result side stalls.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.read_data    <= s1_data;
            r_out.target       <= r_s1_tgt;
            r_out.local_offset <= r_s1_off;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // No beat enters while the memories are being cleared.
    `HMMD_ASSERT_IMP(a_no_acc_clr, i_clk, i_rst_n, r_clr_busy, !acc)
    // Once the boot overlay is off it stays off.
    `HMMD_ASSERT_NXT(a_boot_sticky, i_clk, i_rst_n, !r_boot_on, !r_boot_on)
    // An interrupt event, or a joypad event that changes the buttons, leaves only the
    // five request bits.
    `HMMD_ASSERT_NXT(a_if_masked, i_clk, i_rst_n,
        acc && (i_in_data.mode == MODE_IRQ ||
        (i_in_data.mode == MODE_PAD && i_in_data.buttons != r_pad)), r_if[7:5] == 3'b000)
    // A DMA start carries a page-aligned source base.
    `HMMD_ASSERT_IMP(a_dma_aligned, i_clk, i_rst_n,
        o_out_valid && o_out_data.target == TGT_DMA, o_out_data.local_offset[7:0] == 8'h00)
    // A full pipeline with a stalled result stalls the input.
    `HMMD_ASSERT_IMP(a_back_press, i_clk, i_rst_n,
        r_s1_vld && r_out_vld && i_out_stall, o_in_stall)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the handheld memory map decoder core.
// It keeps its own copy of the memory map state and predicts every result beat.
// It depends only on hmmd_pkg and the core module.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hmmd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    // Clock, reset and the two channels.
    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_beat  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_data;

    // Flow-control knobs and run bookkeeping.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int beats_sent    = 0;
    int beats_checked = 0;

    // Results still owed by the block, oldest first.
    t_out_beat   pending_results[$];
    // Recently written addresses, so that reads find stored data.
    logic [15:0] written_addrs[$];

    // Our own copy of the memory map state.
    logic [7:0] wram_copy [WORK_RAM_BYTES];
    logic [7:0] eram_copy [8192];
    logic [7:0] hram_copy [HIGH_RAM_BYTES];
    logic [7:0] oam_copy  [SPRITE_BYTES];
    logic       boot_on_copy   = 1'b1;
    logic [4:0] irq_en_copy    = '0;
    logic [7:0] irq_req_copy   = '0;
    logic [7:0] speed_copy     = '0;
    logic [1:0] pad_sel_copy   = '0;
    logic [7:0] pad_state_copy = '0;

    initial begin
        foreach (wram_copy[i]) wram_copy[i] = '0;
        foreach (eram_copy[i]) eram_copy[i] = '0;
        foreach (hram_copy[i]) hram_copy[i] = '0;
        foreach (oam_copy[i])  oam_copy[i]  = '0;
    end

    handheld_memory_map_decoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #1 i_clk = ~i_clk;

    // Joypad register as the processor sees it.
    function automatic logic [7:0] joypad_read();
        if (pad_sel_copy[1]) begin
            return 8'h20 | {4'h0, ~pad_state_copy[3:0]};
        end
        if (pad_sel_copy[0]) begin
            return 8'h10 | {4'h0, ~pad_state_copy[7:4]};
        end
        return 8'h0F;
    endfunction

    // Routing of the IO page outside the fixed registers.
    function automatic t_target route_io_page(input logic [7:0] lo, output logic [15:0] off);
        off = '0;
        if (lo < 8'h10) begin
            if (lo == 8'h01 || lo == 8'h02 || (lo >= 8'h04 && lo <= 8'h07)) begin
                off = {8'h00, lo};
                return TGT_TIMER;
            end
            return TGT_INTERNAL;
        end
        if (lo < 8'h40) begin
            off = {8'h00, lo} - 16'h0010;
            return TGT_SOUND;
        end
        if (lo < 8'h50) begin
            off = {8'h00, lo} - 16'h0040;
            return TGT_VIDEO;
        end
        return TGT_INTERNAL;
    endfunction

    // Expected result of one accepted beat; updates the state copy as the block would.
    function automatic t_out_beat decode_access(input t_in_beat beat);
        t_out_beat   res;
        t_target     tgt;
        logic [15:0] a;
        logic [15:0] off;
        logic [7:0]  v;
        res = '{read_data: 8'h00, target: TGT_INTERNAL, local_offset: 16'h0000};
        a = beat.address;
        v = beat.write_data;
        case (beat.mode)
            MODE_READ: begin
                if (a < 16'h8000) begin
                    res.local_offset = a;
                    res.target = (boot_on_copy && a < 16'h0100) ? TGT_BOOT : TGT_CART;
                end else if (a < 16'hA000) begin
                    res.target = TGT_VRAM;
                    res.local_offset = a & 16'h1FFF;
                end else if (a < 16'hC000) begin
                    res.read_data = eram_copy[a[12:0]];
                end else if (a < 16'hFE00) begin
                    res.read_data = wram_copy[a[12:0]];
                end else if (a < 16'hFF00) begin
                    if (a < 16'hFEA0) res.read_data = oam_copy[a[7:0]];
                end else if (a == ADDR_IE) begin
                    res.read_data = {3'b000, irq_en_copy};
                end else if (a >= 16'hFF80) begin
                    res.read_data = hram_copy[a[6:0]];
                end else if (a == ADDR_BOOT) begin
                    res.read_data = {7'd0, boot_on_copy};
                end else if (a == ADDR_SPEED) begin
                    res.read_data = speed_copy;
                end else if (a == ADDR_PAD) begin
                    res.read_data = joypad_read();
                end else if (a == ADDR_IF) begin
                    res.read_data = irq_req_copy;
                end else begin
                    res.target = route_io_page(a[7:0], off);
                    res.local_offset = off;
                end
            end
            MODE_WRITE: begin
                if (a < 16'h8000) begin
                    res.target = TGT_IGNORED;
                end else if (a < 16'hA000) begin
                    res.target = TGT_VRAM;
                    res.local_offset = a & 16'h1FFF;
                end else if (a < 16'hC000) begin
                    eram_copy[a[12:0]] = v;
                end else if (a < 16'hFE00) begin
                    wram_copy[a[12:0]] = v;
                end else if (a < 16'hFF00) begin
                    if (a < 16'hFEA0) oam_copy[a[7:0]] = v;
                    else res.target = TGT_IGNORED;
                end else if (a == ADDR_IE) begin
                    irq_en_copy = v[4:0];
                end else if (a >= 16'hFF80) begin
                    hram_copy[a[6:0]] = v;
                end else if (a == ADDR_DMA) begin
                    res.target = TGT_DMA;
                    res.local_offset = {v, 8'h00};
                end else if (a == ADDR_BOOT) begin
                    if (v != 8'h00) boot_on_copy = 1'b0;
                end else if (a == ADDR_SPEED) begin
                    speed_copy = v;
                end else if (a == ADDR_PAD) begin
                    pad_sel_copy = {~v[5], ~v[4]};
                end else if (a == ADDR_IF) begin
                    irq_req_copy = v;
                end else begin
                    tgt = route_io_page(a[7:0], off);
                    res.target = (tgt == TGT_INTERNAL) ? TGT_IGNORED : tgt;
                    res.local_offset = off;
                end
            end
            MODE_PAD: begin
                if (beat.buttons != pad_state_copy) begin
                    pad_state_copy = beat.buttons;
                    irq_req_copy = (irq_req_copy | IRQ_PAD) & IRQ_MASK;
                end
            end
            default: begin
                irq_req_copy = (irq_req_copy | {3'b000, beat.irq_bits}) & IRQ_MASK;
            end
        endcase
        return res;
    endfunction

    // Offer one beat after a random gap and hold it until the block takes it.
    task automatic send_beat(input t_in_beat beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pending_results.push_back(decode_access(beat));
        beats_sent++;
    endtask

    task automatic send_access(input logic [1:0] mode, input logic [15:0] addr,
                               input logic [7:0] data);
        send_beat('{mode: mode, address: addr, write_data: data, buttons: 8'h00,
                    irq_bits: 5'h00});
    endtask

    task automatic send_event(input logic [1:0] mode, input logic [7:0] buttons,
                              input logic [4:0] irq);
        send_beat('{mode: mode, address: 16'h0000, write_data: 8'h00, buttons: buttons,
                    irq_bits: irq});
    endtask

    // Stop offering beats and wait until every owed result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Address biased toward the regions and registers of the map.
    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        logic [15:0] fixed_regs[6];
        fixed_regs = '{ADDR_PAD, ADDR_IF, ADDR_DMA, ADDR_SPEED, ADDR_BOOT, ADDR_IE};
        case ($urandom_range(0, 11))
            0: a = 16'($urandom_range(0, 16'hFFFF));
            1: a = 16'($urandom_range(0, 16'h7FFF));
            2: a = 16'($urandom_range(16'h8000, 16'h9FFF));
            3: a = 16'($urandom_range(16'hA000, 16'hBFFF));
            4: a = 16'($urandom_range(16'hC000, 16'hFDFF));
            5: a = 16'($urandom_range(16'hFE00, 16'hFEFF));
            6: a = 16'($urandom_range(16'hFF00, 16'hFF7F));
            7: a = 16'($urandom_range(16'hFF80, 16'hFFFF));
            8: a = fixed_regs[$urandom_range(0, 5)];
            default: begin
                if (written_addrs.size() == 0) begin
                    a = 16'($urandom_range(0, 16'hFFFF));
                end else begin
                    a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                end
                // Reach work RAM through its echo and back.
                if (a >= 16'hC000 && a < 16'hFE00 && a[12:0] < 13'h1E00 && $urandom_range(0, 1))
                    a = a ^ 16'h2000;
            end
        endcase
        return a;
    endfunction

    // Random beat: mostly accesses, some joypad and interrupt events.
    function automatic t_in_beat random_beat();
        t_in_beat beat;
        int       pick;
        beat = '{mode: 2'($urandom_range(0, 3)), address: pick_address(),
                 write_data: 8'($urandom_range(0, 255)), buttons: 8'($urandom_range(0, 255)),
                 irq_bits: 5'($urandom_range(0, 31))};
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            beat.mode = MODE_READ;
        end else if (pick < 8) begin
            beat.mode = MODE_WRITE;
            written_addrs.push_back(beat.address);
            if (written_addrs.size() > 48) void'(written_addrs.pop_front());
        end else if (pick == 8) begin
            beat.mode = MODE_PAD;
            // Repeat the current buttons now and then, which must not raise a request.
            if ($urandom_range(0, 2) == 0) beat.buttons = pad_state_copy;
        end else begin
            beat.mode = MODE_IRQ;
        end
        return beat;
    endfunction

    // Receiver side: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req <= 0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation pending: %h", out_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                if (out_data.read_data !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h", want.read_data,
                           out_data.read_data);
                    fail_count++;
                end
                if (out_data.target !== want.target) begin
                    $error("target: expected %0d, got %0d", want.target, out_data.target);
                    fail_count++;
                end
                if (out_data.local_offset !== want.local_offset) begin
                    $error("local_offset: expected %0h, got %0h", want.local_offset,
                           out_data.local_offset);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ROM, boot ROM and video RAM routing, and a dropped ROM write, while the boot overlay is still on.
    task automatic test_rom_and_vram_routing();
        send_access(MODE_READ, 16'h0000, 8'h00);
        send_access(MODE_READ, 16'h00FF, 8'h00);
        send_access(MODE_READ, 16'h0100, 8'h00);
        send_access(MODE_READ, 16'h8000, 8'h00);
        send_access(MODE_READ, 16'h9FFF, 8'h00);
        send_access(MODE_WRITE, 16'h7FFF, 8'hFF);
    endtask

    // Work RAM with its echo, sprite memory and the unused area above it.
    task automatic test_internal_memories();
        send_access(MODE_WRITE, 16'hC000, 8'hA5);
        send_access(MODE_READ, 16'hE000, 8'h00);
        send_access(MODE_WRITE, 16'hFDFF, 8'h5A);
        send_access(MODE_READ, 16'hDDFF, 8'h00);
        send_access(MODE_WRITE, 16'hFE9F, 8'h3C);
        send_access(MODE_READ, 16'hFE9F, 8'h00);
        send_access(MODE_WRITE, 16'hFEA0, 8'hFF);
        send_access(MODE_READ, 16'hFEFF, 8'h00);
    endtask

    // Interrupt enable masking, DMA start, and unmapped and routed IO.
    task automatic test_io_registers();
        send_access(MODE_WRITE, ADDR_IE, 8'hFF);
        send_access(MODE_READ, ADDR_IE, 8'h00);
        send_access(MODE_WRITE, ADDR_DMA, 8'hFF);
        send_access(MODE_READ, ADDR_DMA, 8'h00);
        send_access(MODE_READ, 16'hFF03, 8'h00);
        send_access(MODE_WRITE, 16'hFF7F, 8'h11);
        send_access(MODE_READ, 16'hFF05, 8'h00);
    endtask

    // Joypad group select, button change request and external requests.
    task automatic test_joypad_and_irq();
        send_access(MODE_WRITE, ADDR_PAD, 8'h10);
        send_event(MODE_PAD, 8'hFF, 5'h00);
        send_access(MODE_READ, ADDR_PAD, 8'h00);
        send_event(MODE_PAD, 8'hFF, 5'h1F);
        send_event(MODE_IRQ, 8'h00, 5'h1F);
        send_access(MODE_READ, ADDR_IF, 8'h00);
    endtask

    // A zero write keeps the overlay; a nonzero write removes it for good.
    task automatic test_boot_overlay();
        send_access(MODE_WRITE, ADDR_BOOT, 8'h00);
        send_access(MODE_READ, ADDR_BOOT, 8'h00);
        send_access(MODE_WRITE, ADDR_BOOT, 8'h80);
        send_access(MODE_READ, 16'h0000, 8'h00);
    endtask

    // Random traffic under one flow-control pattern.
    task automatic run_random_traffic(input int beats, input int idle_pct, input int stall_in);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        repeat (beats) send_beat(random_beat());
    endtask

    // Receiver holds off while the sender keeps offering; then the sender pauses and resumes.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req     <= HOLD_CYCLES;
        repeat (40) send_beat(random_beat());
        wait_for_results();
        repeat (10) send_beat(random_beat());
    endtask

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rom_and_vram_routing();
        test_internal_memories();
        test_io_registers();
        test_joypad_and_irq();
        test_boot_overlay();
        run_random_traffic(255, 0, 0);
        run_random_traffic(255, 83, 0);
        run_random_traffic(255, 0, 83);
        run_random_traffic(255, 16, 16);
        test_backpressure();
        stall_pct = 0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d beats and checked %0d results: routing, memories, registers,",
                 beats_sent, beats_checked);
        $display("joypad and interrupt events, with idle, stall and long hold-off phases.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== handheld_memory_map_decoder_core.f =====
+incdir+rtl
rtl/hmmd_pkg.sv
rtl/handheld_memory_map_decoder_core.sv
tb/sv/tb_top.sv
